FILE: sv/aegis_pkg.sv
// shared types, constants and byte-level helpers for the aegis-256 state update
package aegis_pkg;

    localparam int NUM_WORDS  = 12;
    localparam int NUM_BLOCKS = 6;
    localparam int WORD_W     = 64;
    localparam int BLOCK_W    = 2 * WORD_W;
    localparam int INDEX_W    = 4;

    // item kinds
    localparam logic KIND_ABSORB = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [BLOCK_W-1:0]                block_t;
    typedef logic [NUM_WORDS-1:0][WORD_W-1:0]  state_t;
    typedef logic [INDEX_W-1:0]                index_t;

    // one input item as held in the input register
    typedef struct packed {
        logic   kind;
        index_t word_index;
        word_t  load_word;
        word_t  msg_lo;
        word_t  msg_hi;
    } item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

FILE: sv/aegis256_state_update_top.sv
// result path: an input transfer fills the input register, then the state register
// throughput: one item per cycle while out_ready is high; the state register doubles as
// the result register, and the next item's update runs as the previous result is taken
// reset: rst_n clears both valid flags and all twelve state words to zero
// no clearing pass; the block accepts items from the first cycle after reset
module aegis256_state_update_top (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  aegis_pkg::index_t        word_index,
    input  aegis_pkg::word_t         load_word,
    input  aegis_pkg::word_t         msg_lo,
    input  aegis_pkg::word_t         msg_hi,
    output logic                     out_valid,
    input  logic                     out_ready,
    output aegis_pkg::word_t         s0_lo,
    output aegis_pkg::word_t         s0_hi,
    output aegis_pkg::word_t         s1_lo,
    output aegis_pkg::word_t         s1_hi,
    output aegis_pkg::word_t         s2_lo,
    output aegis_pkg::word_t         s2_hi,
    output aegis_pkg::word_t         s3_lo,
    output aegis_pkg::word_t         s3_hi,
    output aegis_pkg::word_t         s4_lo,
    output aegis_pkg::word_t         s4_hi,
    output aegis_pkg::word_t         s5_lo,
    output aegis_pkg::word_t         s5_hi
);

    logic              item_valid_reg;
    logic              item_valid_next;
    aegis_pkg::item_t  item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    aegis_pkg::state_t state_reg;
    aegis_pkg::state_t state_next;
    logic              advance;
    logic              in_xfer;

    // the held item moves on once the result slot is free or being emptied
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    aegis_next u_next (
        .item      (item_reg),
        .state_cur (state_reg),
        .state_nxt (state_next)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_xfer)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.kind       <= kind;
            item_reg.word_index <= word_index;
            item_reg.load_word  <= load_word;
            item_reg.msg_lo     <= msg_lo;
            item_reg.msg_hi     <= msg_hi;
        end
    end

    assign out_valid = out_valid_reg;
    assign s0_lo     = state_reg[0];
    assign s0_hi     = state_reg[1];
    assign s1_lo     = state_reg[2];
    assign s1_hi     = state_reg[3];
    assign s2_lo     = state_reg[4];
    assign s2_hi     = state_reg[5];
    assign s3_lo     = state_reg[6];
    assign s3_hi     = state_reg[7];
    assign s4_lo     = state_reg[8];
    assign s4_hi     = state_reg[9];
    assign s5_lo     = state_reg[10];
    assign s5_hi     = state_reg[11];

endmodule

FILE: sv/aegis_round.sv
// one keyless aes round: subbytes, shiftrows, mixcolumns
module aegis_round (
    input  aegis_pkg::block_t blk_in,
    output aegis_pkg::block_t blk_out
);

    logic [7:0] t [16];

    // byte k of the block is row k mod 4, column k div 4
    for (genvar c = 0; c < 4; c++)
    begin : g_sub
        for (genvar r = 0; r < 4; r++)
        begin : g_row
            localparam int SRC = r + 4 * ((c + r) % 4);
            assign t[r + 4 * c] = aegis_pkg::SBOX[blk_in[8 * SRC +: 8]];
        end
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_mix
        logic [7:0] a0, a1, a2, a3;
        logic [7:0] d0, d1, d2, d3;
        assign a0 = t[4 * c];
        assign a1 = t[4 * c + 1];
        assign a2 = t[4 * c + 2];
        assign a3 = t[4 * c + 3];
        assign d0 = aegis_pkg::xtime(a0);
        assign d1 = aegis_pkg::xtime(a1);
        assign d2 = aegis_pkg::xtime(a2);
        assign d3 = aegis_pkg::xtime(a3);
        assign blk_out[8 * (4 * c)     +: 8] = d0 ^ d1 ^ a1 ^ a2 ^ a3;
        assign blk_out[8 * (4 * c + 1) +: 8] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
        assign blk_out[8 * (4 * c + 2) +: 8] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
        assign blk_out[8 * (4 * c + 3) +: 8] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
    end

endmodule

FILE: sv/aegis_next.sv
// next-state logic: six parallel rounds for an absorb, single word write for a load
module aegis_next (
    input  aegis_pkg::item_t  item,
    input  aegis_pkg::state_t state_cur,
    output aegis_pkg::state_t state_nxt
);

    aegis_pkg::state_t upd;
    aegis_pkg::state_t ld;

    for (genvar i = 0; i < aegis_pkg::NUM_BLOCKS; i++)
    begin : g_blk
        localparam int PREV = (i + aegis_pkg::NUM_BLOCKS - 1) % aegis_pkg::NUM_BLOCKS;
        aegis_pkg::block_t src;
        aegis_pkg::block_t rnd;
        aegis_pkg::block_t msg;

        assign src = {state_cur[2 * PREV + 1], state_cur[2 * PREV]};
        // only block 0 takes the message
        assign msg = (i == 0) ? {item.msg_hi, item.msg_lo} : '0;

        aegis_round u_round (
            .blk_in  (src),
            .blk_out (rnd)
        );

        assign upd[2 * i]     = rnd[aegis_pkg::WORD_W-1:0] ^ state_cur[2 * i]
                              ^ msg[aegis_pkg::WORD_W-1:0];
        assign upd[2 * i + 1] = rnd[aegis_pkg::BLOCK_W-1:aegis_pkg::WORD_W]
                              ^ state_cur[2 * i + 1]
                              ^ msg[aegis_pkg::BLOCK_W-1:aegis_pkg::WORD_W];
    end

    // an index past the last word matches nothing and leaves the state alone
    for (genvar w = 0; w < aegis_pkg::NUM_WORDS; w++)
    begin : g_load
        assign ld[w] = (item.word_index == aegis_pkg::INDEX_W'(w)) ? item.load_word
                                                                   : state_cur[w];
    end

    assign state_nxt = (item.kind == aegis_pkg::KIND_LOAD) ? ld : upd;

endmodule
